/* hdl/ptt_pkg.sv */
// ptt_pkg: shared constants, word types and helpers for the picture order
// count and timestamp tracker. No dependencies.
`timescale 1ns / 1ps

package ptt_pkg;

  localparam int TIME_WIDTH   = 48;
  localparam int LSB_MAX_BITS = 16;
  localparam int POC_LSB_W    = 16;
  localparam int ORDER_W      = 32;
  localparam int DUR_W        = 24;
  localparam int LOG2_W       = 5;
  localparam int DEPTH_W      = 15;
  localparam int OUT_TIME_W   = 48;
  localparam int CFG_ADDR_W   = 8;
  localparam int PROD_W       = ORDER_W + DUR_W + 1;
  localparam int RANGE_W      = LSB_MAX_BITS + 1;

  localparam logic [LOG2_W-1:0]  LOG2_MIN        = 5'd4;
  localparam logic [LOG2_W-1:0]  LOG2_MAX        = LOG2_W'(LSB_MAX_BITS);
  localparam logic [LOG2_W-1:0]  LOG2_RESET      = 5'd8;
  localparam logic [DUR_W-1:0]   DURATION_RESET  = 24'd1125000;
  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT     = 15'd32767;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET     = 15'd1;

  localparam logic [CFG_ADDR_W-1:0] CFG_LOG2_MAX_POC_LSB = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_DURATION   = 8'd1;

  typedef logic [TIME_WIDTH-1:0] ptt_time_t;

  typedef struct packed {
    logic                 is_idr;
    logic [POC_LSB_W-1:0] poc_lsb;
  } ptt_pic_t;

  typedef struct packed {
    logic signed [ORDER_W-1:0]    full_pic_order;
    logic signed [OUT_TIME_W-1:0] dts;
    logic signed [OUT_TIME_W-1:0] pts;
    logic [DEPTH_W-1:0]           reorder_depth;
    logic                         depth_grew;
  } ptt_res_t;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] addr;
    logic [DUR_W-1:0]      wdata;
  } ptt_cfg_t;

  // sign-extend a time value and cut it to the output field width
  function automatic logic [OUT_TIME_W-1:0] time_out(ptt_time_t v);
    logic signed [63:0] w;
    w = 64'(signed'(v));
    return w[OUT_TIME_W-1:0];
  endfunction

endpackage

/* hdl/ptt_pic_if.sv */
// ptt_pic_if: valid/ready channel carrying one picture word.
// Depends on ptt_pkg.
`timescale 1ns / 1ps

interface ptt_pic_if;
  import ptt_pkg::*;

  logic     valid;
  logic     ready;
  ptt_pic_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/ptt_res_if.sv */
// ptt_res_if: valid/ready channel carrying one result word.
// Depends on ptt_pkg.
`timescale 1ns / 1ps

interface ptt_res_if;
  import ptt_pkg::*;

  logic     valid;
  logic     ready;
  ptt_res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/ptt_cfg_if.sv */
// ptt_cfg_if: valid/ready register write channel (index and write data).
// Depends on ptt_pkg.
`timescale 1ns / 1ps

interface ptt_cfg_if;
  import ptt_pkg::*;

  logic     valid;
  logic     ready;
  ptt_cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/poc_and_timestamp_tracker.sv */
// poc_and_timestamp_tracker: extends picture order count LSBs and derives
// decode/presentation timestamps and the deepest reorder delta.
// Depends on ptt_pkg, ptt_pic_if, ptt_res_if and ptt_cfg_if.
// Each accepted picture word passes through the input register, order stage,
// delta stage, multiply stage and result register to its result word.
// Throughput: one word per cycle; each stage holds only while the stage after
// it is full and stalled. Reset (rst_ni low, async) clears all stage valids
// and the tracker state; registers return to 8 and 1125000.
`timescale 1ns / 1ps

module poc_and_timestamp_tracker (
  input  logic  clk_i,
  input  logic  rst_ni,
  ptt_pic_if.sink   pic_i,
  ptt_cfg_if.sink   cfg_i,
  ptt_res_if.source res_o
);
  import ptt_pkg::*;

  // configuration
  logic [LOG2_W-1:0] log2_lsb_q;
  logic [DUR_W-1:0]  frame_dur_q;

  // tracker state
  logic [ORDER_W-1:0]   frame_count_q, frame_count_d;
  logic [ORDER_W-1:0]   order_base_q, order_base_d;
  logic [ORDER_W-1:0]   order_msb_q, order_msb_d;
  logic [POC_LSB_W-1:0] prev_lsb_q, prev_lsb_d;
  logic [DEPTH_W-1:0]   depth_max_q, depth_max_d;
  ptt_time_t            decode_time_q, decode_time_d;

  // stage valids
  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic ld1, ld2, ld3, ld4;

  // stage payloads
  ptt_pic_t           s0_q;
  logic [ORDER_W-1:0] full1_q, full1_d, fc1_q;
  ptt_time_t          dts1_q;
  logic [ORDER_W-1:0] full2_q, delta2_q;
  ptt_time_t          dts2_q;
  logic [ORDER_W-1:0] full3_q;
  ptt_time_t          dts3_q, prod3_q, prod3_d;
  logic [DEPTH_W-1:0] depth3_q;
  logic               grew3_q, grew3_d;
  ptt_res_t           res_q, res_d;

  logic [LOG2_W-1:0]    bits;
  logic [RANGE_W-1:0]   range, half;
  logic [RANGE_W-1:0]   diff;
  logic signed [PROD_W-1:0] prod_full;
  logic signed [63:0]   prod_ext;
  ptt_time_t            pts3;

  // handshake chain
  assign rdy4        = !v4_q || res_o.ready;
  assign rdy3        = !v3_q || rdy4;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign pic_i.ready = !v0_q || rdy1;
  assign ld1         = v0_q && rdy1;
  assign ld2         = v1_q && rdy2;
  assign ld3         = v2_q && rdy3;
  assign ld4         = v3_q && rdy4;
  assign cfg_i.ready = 1'b1;

  // order stage: msb extension and decode time
  always_comb begin
    if (log2_lsb_q < LOG2_MIN) begin
      bits = LOG2_MIN;
    end else if (log2_lsb_q > LOG2_MAX) begin
      bits = LOG2_MAX;
    end else begin
      bits = log2_lsb_q;
    end
    range = RANGE_W'(1) << bits;
    half  = range >> 1;
    diff  = '0;

    order_base_d = order_base_q;
    order_msb_d  = order_msb_q;
    prev_lsb_d   = prev_lsb_q;
    if (s0_q.is_idr) begin
      order_base_d = frame_count_q;
      order_msb_d  = '0;
      prev_lsb_d   = '0;
    end else begin
      if (s0_q.poc_lsb < prev_lsb_q) begin
        diff = RANGE_W'(prev_lsb_q) - RANGE_W'(s0_q.poc_lsb);
        if (diff >= half) begin
          order_msb_d = order_msb_q + ORDER_W'(range);
        end
      end else if (s0_q.poc_lsb > prev_lsb_q) begin
        diff = RANGE_W'(s0_q.poc_lsb) - RANGE_W'(prev_lsb_q);
        if (diff >= half) begin
          order_msb_d = order_msb_q - ORDER_W'(range);
        end
      end
      prev_lsb_d = s0_q.poc_lsb;
    end
    full1_d = ORDER_W'(s0_q.poc_lsb) + order_msb_d + order_base_d;

    if (frame_count_q != '0) begin
      decode_time_d = decode_time_q + TIME_WIDTH'(frame_dur_q);
    end else begin
      decode_time_d = decode_time_q;
    end
    frame_count_d = frame_count_q + ORDER_W'(1);
  end

  // multiply stage: delta times duration, depth tracking
  always_comb begin
    prod_full = signed'(delta2_q) * signed'({1'b0, frame_dur_q});
    prod_ext  = 64'(prod_full);
    prod3_d   = prod_ext[TIME_WIDTH-1:0];

    depth_max_d = depth_max_q;
    if (!delta2_q[ORDER_W-1] && (delta2_q > ORDER_W'(depth_max_q))) begin
      if (delta2_q > ORDER_W'(DEPTH_LIMIT)) begin
        depth_max_d = DEPTH_LIMIT;
      end else begin
        depth_max_d = delta2_q[DEPTH_W-1:0];
      end
    end
    grew3_d = (depth_max_d != depth_max_q);
  end

  // result stage
  always_comb begin
    pts3                 = dts3_q - prod3_q;
    res_d.full_pic_order = signed'(full3_q);
    res_d.dts            = signed'(time_out(dts3_q));
    res_d.pts            = signed'(time_out(pts3));
    res_d.reorder_depth  = depth3_q;
    res_d.depth_grew     = grew3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_lsb_q  <= LOG2_RESET;
      frame_dur_q <= DURATION_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.data.addr == CFG_LOG2_MAX_POC_LSB) begin
        log2_lsb_q <= cfg_i.data.wdata[LOG2_W-1:0];
      end else if (cfg_i.data.addr == CFG_FRAME_DURATION) begin
        frame_dur_q <= cfg_i.data.wdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= '0;
      order_base_q  <= '0;
      order_msb_q   <= '0;
      prev_lsb_q    <= '0;
      decode_time_q <= '0;
    end else if (ld1) begin
      frame_count_q <= frame_count_d;
      order_base_q  <= order_base_d;
      order_msb_q   <= order_msb_d;
      prev_lsb_q    <= prev_lsb_d;
      decode_time_q <= decode_time_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_max_q <= DEPTH_RESET;
    end else if (ld3) begin
      depth_max_q <= depth_max_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (pic_i.ready) begin
        v0_q <= pic_i.valid;
      end
      if (rdy1) begin
        v1_q <= v0_q;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pic_i.ready && pic_i.valid) begin
      s0_q <= pic_i.data;
    end
    if (ld1) begin
      full1_q <= full1_d;
      fc1_q   <= frame_count_q;
      dts1_q  <= decode_time_d;
    end
    if (ld2) begin
      full2_q  <= full1_q;
      delta2_q <= fc1_q - full1_q;
      dts2_q   <= dts1_q;
    end
    if (ld3) begin
      full3_q  <= full2_q;
      dts3_q   <= dts2_q;
      prod3_q  <= prod3_d;
      depth3_q <= depth_max_d;
      grew3_q  <= grew3_d;
    end
    if (ld4) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = v4_q;
  assign res_o.data  = res_q;

  a_depth_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_max_q != '0)
    else $error("reorder depth dropped to zero");

  a_depth_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> depth_max_q >= $past(depth_max_q))
    else $error("reorder depth decreased");

  a_frame_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld1 |=> frame_count_q == $past(frame_count_q) + ORDER_W'(1))
    else $error("frame count did not advance by one per picture");

  a_idr_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld1 && s0_q.is_idr |=> order_msb_q == '0 && prev_lsb_q == '0)
    else $error("idr picture did not clear order msb and previous lsb");

  a_grew_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld3 && grew3_d |=> depth_max_q != $past(depth_max_q))
    else $error("depth growth flagged without a change of depth");

endmodule
